FILE: hw/rtl/paraboloid_bilinear_lookup_assert.svh
// Assertion macros for the paraboloid bilinear lookup block.
// Used by the top level; needs signals named clk and rst in scope.
`ifndef PARABOLOID_BILINEAR_LOOKUP_ASSERT_SVH
`define PARABOLOID_BILINEAR_LOOKUP_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define PBL_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);
// next-cycle implication
`define PBL_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define PBL_ASSERT_NOW(label, pre, post, msg)
`define PBL_ASSERT_NEXT(label, pre, post, msg)
`endif
`endif

FILE: hw/rtl/pbl_pkg.sv
// Shared constants and types of the paraboloid bilinear lookup block.
// No dependencies; imported by pbl_axis, pbl_ndiv and the top level.
package pbl_pkg;

  localparam int MAX_GRID   = 64;
  localparam int GRID_W     = $clog2(MAX_GRID) + 1;
  localparam int SLOT_DEPTH = MAX_GRID * MAX_GRID;
  localparam int SLOT_AW    = $clog2(SLOT_DEPTH);
  localparam int AREA_DEPTH = 4096;
  localparam int AREA_AW    = $clog2(AREA_DEPTH);
  localparam int SLOT_W     = 13;
  localparam int WGT_W      = 17;
  localparam int Q16_ONE    = 65536;
  // coordinate t is at most grid << 16
  localparam int T_W        = GRID_W + 16;

  typedef enum logic [1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_SLOT   = 2'd1,
    KIND_AREA   = 2'd2
  } kind_t;

  localparam logic CFG_GRID_SIZE = 1'b0;
  localparam logic CFG_UPPER     = 1'b1;

  localparam logic [SLOT_W-1:0] SLOT_EMPTY = {SLOT_W{1'b1}};

  // per-axis pipeline control
  typedef struct packed {
    logic              adv;
    logic              upper;
    logic [GRID_W-1:0] g;
  } axis_ctl_t;

endpackage

FILE: hw/rtl/pbl_ram.sv
// Generic RAM: one write port, two registered read ports with read enable.
// No dependencies.
module pbl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered reads
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

FILE: hw/rtl/pbl_axis.sv
// Axis projection pipeline: t = floor((c+d)*g*32768/d) - 32768, saturated.
// Six register stages; uses pbl_pkg.
module pbl_axis (
  input  logic                       clk,
  input  pbl_pkg::axis_ctl_t         ctl,
  input  logic signed [15:0]         c,
  input  logic signed [15:0]         z,
  output logic [pbl_pkg::T_W-1:0]    t
);
  import pbl_pkg::*;

  localparam int Q_W   = T_W + 1;
  localparam int SH    = Q_W - 15;
  localparam int STEPS = 8;

  typedef struct packed {
    logic [16:0]    rem;
    logic [Q_W-1:0] nb;
    logic [Q_W-1:0] q;
  } div_t;

  // eight restoring division steps
  function automatic div_t div_steps(input div_t s, input logic [15:0] d);
    div_t        r;
    logic [16:0] sh;
    r = s;
    for (int k = 0; k < STEPS; k++) begin
      sh   = {r.rem[15:0], r.nb[Q_W-1]};
      r.nb = r.nb << 1;
      if (sh >= {1'b0, d}) begin
        r.rem = sh - {1'b0, d};
        r.q   = {r.q[Q_W-2:0], 1'b1};
      end else begin
        r.rem = sh;
        r.q   = {r.q[Q_W-2:0], 1'b0};
      end
    end
    return r;
  endfunction

  // stage 1: denominator, sign fold, numerator sum
  logic [16:0] d_raw;
  logic [16:0] c_ext;
  logic [16:0] c_adj;
  logic [15:0] d_abs;
  logic [17:0] sum;

  always_comb begin
    c_ext = {c[15], c};
    d_raw = ctl.upper ? ({z[15], z} + 17'd16384) : (17'd16384 - {z[15], z});
    d_abs = d_raw[16] ? 16'(17'd0 - d_raw) : d_raw[15:0];
    c_adj = d_raw[16] ? (17'd0 - c_ext) : c_ext;
    sum   = {c_adj[16], c_adj} + {2'b00, d_abs};
  end

  logic [17:0] s1_sum;
  logic [15:0] s1_d;
  logic        s1_dzero;
  logic        s1_cpos;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s1_sum   <= sum;
      s1_d     <= d_abs;
      s1_dzero <= (d_raw == 17'd0);
      s1_cpos  <= !c[15];
    end
  end

  // stage 2: scale by grid size
  logic [T_W-1:0] s2_p;
  logic [15:0]    s2_d;
  logic           s2_hi;
  logic           s2_lo;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s2_p  <= T_W'(s1_sum[16:0]) * T_W'(ctl.g);
      s2_d  <= s1_d;
      s2_hi <= s1_dzero && s1_cpos;
      s2_lo <= (s1_dzero && !s1_cpos) || (!s1_dzero && s1_sum[17]);
    end
  end

  // stage 3: overflow check and first quotient bits
  div_t div_init;
  assign div_init = '{rem: 17'(s2_p[T_W-1:SH]), nb: {s2_p[SH-1:0], 15'b0}, q: '0};

  div_t        s3_div;
  logic [15:0] s3_d;
  logic        s3_hi;
  logic        s3_lo;
  logic        s3_ovf;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s3_div <= div_steps(div_init, s2_d);
      s3_d   <= s2_d;
      s3_hi  <= s2_hi;
      s3_lo  <= s2_lo;
      s3_ovf <= (25'(s2_p) >= {s2_d, {SH{1'b0}}});
    end
  end

  // stages 4 and 5: remaining quotient bits
  div_t        s4_div;
  div_t        s5_div;
  logic [15:0] s4_d;
  logic        s4_hi;
  logic        s4_lo;
  logic        s4_ovf;
  logic        s5_hi;
  logic        s5_lo;
  logic        s5_ovf;

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      s4_div <= div_steps(s3_div, s3_d);
      s4_d   <= s3_d;
      s4_hi  <= s3_hi;
      s4_lo  <= s3_lo;
      s4_ovf <= s3_ovf;
      s5_div <= div_steps(s4_div, s4_d);
      s5_hi  <= s4_hi;
      s5_lo  <= s4_lo;
      s5_ovf <= s4_ovf;
    end
  end

  // stage 6: subtract half a texel and saturate
  logic [T_W-1:0] hi;
  logic [Q_W-1:0] tm;
  logic [T_W-1:0] t_next;

  always_comb begin
    hi = {ctl.g, 16'b0};
    tm = s5_div.q - Q_W'(32768);
    if (s5_hi || (!s5_lo && s5_ovf)) begin
      t_next = hi;
    end else if (s5_lo || (s5_div.q < Q_W'(32768))) begin
      t_next = '0;
    end else if (tm > Q_W'(hi)) begin
      t_next = hi;
    end else begin
      t_next = T_W'(tm);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.adv) begin
      t <= t_next;
    end
  end

endmodule

FILE: hw/rtl/pbl_ndiv.sv
// Weight normalization lane: q = w*65536 / sum, three register stages.
// Uses pbl_pkg.
module pbl_ndiv (
  input  logic                        clk,
  input  logic                        adv,
  input  logic [pbl_pkg::WGT_W-1:0]   w,
  input  logic [18:0]                 sum,
  output logic [pbl_pkg::WGT_W-1:0]   q
);
  import pbl_pkg::*;

  typedef struct packed {
    logic [19:0]      rem;
    logic [WGT_W-1:0] nb;
    logic [WGT_W-1:0] q;
  } ndiv_t;

  // up to six restoring steps
  function automatic ndiv_t ndiv_steps(input ndiv_t s, input logic [18:0] d, input int n);
    ndiv_t       r;
    logic [19:0] sh;
    r = s;
    for (int k = 0; k < 6; k++) begin
      if (k < n) begin
        sh   = {r.rem[18:0], r.nb[WGT_W-1]};
        r.nb = r.nb << 1;
        if (sh >= {1'b0, d}) begin
          r.rem = sh - {1'b0, d};
          r.q   = {r.q[WGT_W-2:0], 1'b1};
        end else begin
          r.rem = sh;
          r.q   = {r.q[WGT_W-2:0], 1'b0};
        end
      end
    end
    return r;
  endfunction

  // w <= sum, so w >> 1 is already below the divisor
  ndiv_t init;
  assign init = '{rem: 20'(w[WGT_W-1:1]), nb: {w[0], 16'b0}, q: '0};

  ndiv_t       n1;
  ndiv_t       n2;
  ndiv_t       n3;
  logic [18:0] n1_d;
  logic [18:0] n2_d;

  always_ff @(posedge clk) begin
    if (adv) begin
      n1   <= ndiv_steps(init, sum, 6);
      n1_d <= sum;
      n2   <= ndiv_steps(n1, n1_d, 6);
      n2_d <= n1_d;
      n3   <= ndiv_steps(n2, n2_d, 5);
    end
  end

  assign q = n3.q;

endmodule

FILE: hw/rtl/paraboloid_bilinear_lookup.sv
// Top level of the paraboloid bilinear lookup block.
// Uses pbl_pkg, pbl_ram, pbl_axis, pbl_ndiv and the assertion header.
`include "paraboloid_bilinear_lookup_assert.svh"

// A request is taken when start is high and busy is low. A lookup request,
// once through the pipeline, puts its results on the result ports one result
// per cycle: one for each contributing neighbour (up to four), or a single
// empty result when none contributes, so a lookup gives one to four results.
// Table write requests give no result and are taken one per cycle while busy
// is low. The single result port sets the sustained lookup rate. Results
// cannot be held off; busy rises while the result buffer still holds results
// beyond the one being shown and the next lookup has reached the end of the
// pipeline. After reset the slot table is cleared to empty, one entry a
// cycle, so busy stays high while the pass runs. Configuration writes must
// only be made while no request is in flight.
module paraboloid_bilinear_lookup (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [6:0]         cfg_data,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         kind,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic               use_area,
  input  logic               normalize_weights,
  input  logic [11:0]        table_address,
  input  logic signed [17:0] table_value,
  output logic               strobe,
  output logic signed [12:0] slot_index,
  output logic [16:0]        weight,
  output logic               valid_res,
  output logic               last
);
  import pbl_pkg::*;

  localparam int LAST = 13;

  typedef struct packed {
    logic        vld;
    logic [1:0]  kind;
    logic        use_area;
    logic        norm;
    logic [11:0] addr;
    logic [17:0] value;
  } item_t;

  typedef struct packed {
    logic [3:0]                   contrib;
    logic [3:0][SLOT_W-1:0]       slot;
    logic [3:0][WGT_W-1:0]        w;
  } lanes_t;

  // configuration registers
  logic [6:0]        grid_size;
  logic              upper_hemisphere;
  logic [GRID_W-1:0] g;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_size        <= 7'(MAX_GRID);
      upper_hemisphere <= 1'b1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRID_SIZE: grid_size        <= cfg_data;
        CFG_UPPER:     upper_hemisphere <= cfg_data[0];
        default: ;
      endcase
    end
  end

  assign g = (grid_size > 7'(MAX_GRID)) ? GRID_W'(MAX_GRID) : GRID_W'(grid_size);

  // slot table clearing pass
  logic               clearing;
  logic [SLOT_AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + 1'b1;
      if (clr_addr == SLOT_AW'(SLOT_DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // request pipeline control
  logic  adv;
  logic  accept;
  item_t side [LAST+1];
  logic signed [15:0] in_dx;
  logic signed [15:0] in_dy;
  logic signed [15:0] in_dz;

  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i <= LAST; i++) begin
        side[i].vld <= 1'b0;
      end
    end else if (adv) begin
      side[0].vld      <= accept;
      side[0].kind     <= kind;
      side[0].use_area <= use_area;
      side[0].norm     <= normalize_weights;
      side[0].addr     <= table_address;
      side[0].value    <= table_value;
      for (int i = 1; i <= LAST; i++) begin
        side[i] <= side[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      in_dx <= dir_x;
      in_dy <= dir_y;
      in_dz <= dir_z;
    end
  end

  // projection of both axes
  axis_ctl_t      ax_ctl;
  logic [T_W-1:0] tx;
  logic [T_W-1:0] ty;

  assign ax_ctl = '{adv: adv, upper: upper_hemisphere, g: g};

  pbl_axis u_axis_x (.clk(clk), .ctl(ax_ctl), .c(in_dx), .z(in_dz), .t(tx));
  pbl_axis u_axis_y (.clk(clk), .ctl(ax_ctl), .c(in_dy), .z(in_dz), .t(ty));

  // neighbour coordinates, grid checks and slot addresses
  logic [GRID_W:0]     x0;
  logic [GRID_W:0]     x1;
  logic [GRID_W:0]     y0;
  logic [GRID_W:0]     y1;
  logic [2*GRID_W-1:0] row0;
  logic [2*GRID_W-1:0] row1;
  logic [SLOT_AW-1:0]  rd_addr [4];
  logic [3:0]          on_grid;

  always_comb begin
    x0   = {1'b0, tx[T_W-1:16]};
    y0   = {1'b0, ty[T_W-1:16]};
    x1   = x0 + 1'b1;
    y1   = y0 + 1'b1;
    row0 = (2*GRID_W)'(y0[GRID_W-1:0]) * (2*GRID_W)'(g);
    row1 = row0 + (2*GRID_W)'(g);
    rd_addr[0] = SLOT_AW'((2*GRID_W)'(x0) + row0);
    rd_addr[1] = SLOT_AW'((2*GRID_W)'(x1) + row0);
    rd_addr[2] = SLOT_AW'((2*GRID_W)'(x0) + row1);
    rd_addr[3] = SLOT_AW'((2*GRID_W)'(x1) + row1);
    on_grid[0] = (x0 < {1'b0, g}) && (y0 < {1'b0, g});
    on_grid[1] = (x1 < {1'b0, g}) && (y0 < {1'b0, g});
    on_grid[2] = (x0 < {1'b0, g}) && (y1 < {1'b0, g});
    on_grid[3] = (x1 < {1'b0, g}) && (y1 < {1'b0, g});
  end

  logic [3:0]       s7_in;
  logic [WGT_W-1:0] s7_wx [2];
  logic [WGT_W-1:0] s7_wy [2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s7_in    <= on_grid;
      s7_wx[0] <= WGT_W'(Q16_ONE) - {1'b0, tx[15:0]};
      s7_wx[1] <= {1'b0, tx[15:0]};
      s7_wy[0] <= WGT_W'(Q16_ONE) - {1'b0, ty[15:0]};
      s7_wy[1] <= {1'b0, ty[15:0]};
    end
  end

  // slot table, duplicated for four reads a cycle
  logic              slot_we;
  logic [SLOT_AW-1:0] slot_waddr;
  logic [SLOT_W-1:0]  slot_wdata;
  logic [SLOT_W-1:0]  slot_val;
  logic [SLOT_W-1:0]  slot_rd [4];

  always_comb begin
    if (side[6].value[17]) begin
      slot_val = SLOT_EMPTY;
    end else if (side[6].value[16:12] != 5'd0) begin
      slot_val = SLOT_W'(4095);
    end else begin
      slot_val = side[6].value[SLOT_W-1:0];
    end
    slot_we    = clearing || (adv && side[6].vld && (side[6].kind == KIND_SLOT)
                 && ({1'b0, side[6].addr} < 13'(SLOT_DEPTH)));
    slot_waddr = clearing ? clr_addr : SLOT_AW'(side[6].addr);
    slot_wdata = clearing ? SLOT_EMPTY : slot_val;
  end

  pbl_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot_lo (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata), .re(adv),
    .raddr_a(rd_addr[0]), .raddr_b(rd_addr[1]),
    .rdata_a(slot_rd[0]), .rdata_b(slot_rd[1])
  );

  pbl_ram #(.WIDTH(SLOT_W), .DEPTH(SLOT_DEPTH)) u_slot_hi (
    .clk(clk), .we(slot_we), .waddr(slot_waddr), .wdata(slot_wdata), .re(adv),
    .raddr_a(rd_addr[2]), .raddr_b(rd_addr[3]),
    .rdata_a(slot_rd[2]), .rdata_b(slot_rd[3])
  );

  // bilinear products and contributing lanes
  logic [33:0] prod [4];
  lanes_t      s8;

  always_comb begin
    prod[0] = 34'(s7_wx[0]) * 34'(s7_wy[0]);
    prod[1] = 34'(s7_wx[1]) * 34'(s7_wy[0]);
    prod[2] = 34'(s7_wx[0]) * 34'(s7_wy[1]);
    prod[3] = 34'(s7_wx[1]) * 34'(s7_wy[1]);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int n = 0; n < 4; n++) begin
        s8.contrib[n] <= s7_in[n] && !slot_rd[n][SLOT_W-1];
        s8.slot[n]    <= slot_rd[n];
        s8.w[n]       <= prod[n][32:16];
      end
    end
  end

  // area table, duplicated for four reads a cycle
  logic             area_we;
  logic [WGT_W-1:0] area_wdata;
  logic [WGT_W-1:0] area_rd [4];

  always_comb begin
    area_we = adv && side[7].vld && (side[7].kind == KIND_AREA);
    if (side[7].value[17]) begin
      area_wdata = '0;
    end else if (side[7].value[16:0] > WGT_W'(Q16_ONE)) begin
      area_wdata = WGT_W'(Q16_ONE);
    end else begin
      area_wdata = side[7].value[16:0];
    end
  end

  pbl_ram #(.WIDTH(WGT_W), .DEPTH(AREA_DEPTH)) u_area_lo (
    .clk(clk), .we(area_we), .waddr(AREA_AW'(side[7].addr)), .wdata(area_wdata),
    .re(adv),
    .raddr_a(AREA_AW'(slot_rd[0])), .raddr_b(AREA_AW'(slot_rd[1])),
    .rdata_a(area_rd[0]), .rdata_b(area_rd[1])
  );

  pbl_ram #(.WIDTH(WGT_W), .DEPTH(AREA_DEPTH)) u_area_hi (
    .clk(clk), .we(area_we), .waddr(AREA_AW'(side[7].addr)), .wdata(area_wdata),
    .re(adv),
    .raddr_a(AREA_AW'(slot_rd[2])), .raddr_b(AREA_AW'(slot_rd[3])),
    .rdata_a(area_rd[2]), .rdata_b(area_rd[3])
  );

  // area scaling; lanes that do not contribute carry zero weight
  logic [33:0] aprod [4];
  lanes_t      s9;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      aprod[n] = 34'(s8.w[n]) * 34'(area_rd[n]);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s9.contrib <= s8.contrib;
      s9.slot    <= s8.slot;
      for (int n = 0; n < 4; n++) begin
        if (!s8.contrib[n]) begin
          s9.w[n] <= '0;
        end else if (side[8].use_area) begin
          s9.w[n] <= aprod[n][32:16];
        end else begin
          s9.w[n] <= s8.w[n];
        end
      end
    end
  end

  // weight sum
  lanes_t      s10;
  logic [18:0] s10_sum;

  always_ff @(posedge clk) begin
    if (adv) begin
      s10     <= s9;
      s10_sum <= 19'(s9.w[0]) + 19'(s9.w[1]) + 19'(s9.w[2]) + 19'(s9.w[3]);
    end
  end

  // normalization lanes, aligned with stages 11 to 13
  logic [WGT_W-1:0] nq [4];
  lanes_t           ln [11:13];
  logic             sz [11:13];

  for (genvar n = 0; n < 4; n++) begin : g_ndiv
    pbl_ndiv u_ndiv (
      .clk(clk), .adv(adv), .w(s10.w[n]), .sum(s10_sum), .q(nq[n])
    );
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ln[11] <= s10;
      sz[11] <= (s10_sum == 19'd0);
      ln[12] <= ln[11];
      sz[12] <= sz[11];
      ln[13] <= ln[12];
      sz[13] <= sz[12];
    end
  end

  // result buffer, drained one result per cycle
  logic [3:0]             buf_mask;
  logic                   buf_none;
  logic [3:0][SLOT_W-1:0] buf_slot;
  logic [3:0][WGT_W-1:0]  buf_w;
  logic [3:0]             low;
  logic [3:0]             rest;
  logic [1:0]             sel;
  logic                   hold;
  logic                   load;

  always_comb begin
    low  = buf_mask & (~buf_mask + 4'd1);
    rest = buf_mask & ~low;
    hold = (rest != 4'd0);
    case (low)
      4'b0010: sel = 2'd1;
      4'b0100: sel = 2'd2;
      4'b1000: sel = 2'd3;
      default: sel = 2'd0;
    endcase
  end

  assign load = side[LAST].vld && (side[LAST].kind == KIND_LOOKUP);
  assign adv  = !(load && hold);
  assign busy = clearing || !adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_mask <= '0;
      buf_none <= 1'b0;
    end else if (adv && load) begin
      buf_mask <= ln[LAST].contrib;
      buf_none <= (ln[LAST].contrib == 4'd0);
    end else begin
      buf_mask <= rest;
      buf_none <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && load) begin
      buf_slot <= ln[LAST].slot;
      for (int n = 0; n < 4; n++) begin
        if (!side[LAST].norm) begin
          buf_w[n] <= ln[LAST].w[n];
        end else if (sz[LAST]) begin
          buf_w[n] <= '0;
        end else begin
          buf_w[n] <= nq[n];
        end
      end
    end
  end

  // result ports
  always_comb begin
    strobe = (buf_mask != 4'd0) || buf_none;
    if (buf_mask != 4'd0) begin
      slot_index = buf_slot[sel];
      weight     = buf_w[sel];
      valid_res  = 1'b1;
      last       = !hold;
    end else begin
      slot_index = SLOT_EMPTY;
      weight     = '0;
      valid_res  = 1'b0;
      last       = buf_none;
    end
  end

  // checks
  `PBL_ASSERT_NEXT(a_burst_gapless, strobe && !last, strobe, "result burst broken before last")
  `PBL_ASSERT_NOW(a_empty_single, strobe && !valid_res, last && (weight == '0), "bad empty result")
  `PBL_ASSERT_NOW(a_slot_used, strobe && valid_res, !slot_index[SLOT_W-1], "empty slot emitted")
  `PBL_ASSERT_NOW(a_weight_range, strobe, weight <= WGT_W'(Q16_ONE), "weight above one")

endmodule
